@@ rtl/core/rcpl_pkg.sv @@
// shared types and constants of the rc pulse light controller
package rcpl_pkg;

  localparam int unsigned NumChannelsDefault = 2;

  localparam int unsigned TickW = 16;
  localparam int unsigned PosW  = 8;
  localparam int unsigned DutyW = 10;
  localparam int unsigned HoldW = 11;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [TickW-1:0] WidthMin = 16'd4000;
  localparam logic [TickW-1:0] WidthMax = 16'd8000;

  localparam logic [PosW-1:0]  PosNone      = 8'hFF;
  localparam logic [PosW-1:0]  NeutralReset = 8'd125;
  localparam logic [DutyW-1:0] DutyFull     = 10'h3FF;
  localparam logic [DutyW-1:0] DutyInit     = 10'd256;

  localparam logic [TickW-1:0] PeriodReset  = 16'd4000;
  localparam logic [HoldW-1:0] HoldReset    = 11'd1000;
  localparam logic [PosW-1:0]  OnBelowReset = 8'd100;
  localparam logic [PosW-1:0]  OffAboveReset = 8'd150;
  localparam logic [PosW-1:0]  BrakeReset   = 8'd23;
  localparam logic [PosW-1:0]  ReleaseReset = 8'd5;
  localparam logic [DutyW-1:0] TailReset    = 10'd256;

  typedef enum logic [2:0] {
    RegControlPeriod,
    RegButtonHold,
    RegLightOnBelow,
    RegLightOffAbove,
    RegBrakeMargin,
    RegReleaseMargin,
    RegTailDuty
  } reg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] control_period;
    logic [HoldW-1:0] button_hold_steps;
    logic [PosW-1:0]  light_on_below;
    logic [PosW-1:0]  light_off_above;
    logic [PosW-1:0]  brake_margin;
    logic [PosW-1:0]  release_margin;
    logic [DutyW-1:0] tail_duty;
  } cfg_t;

endpackage

@@ rtl/core/rcpl_pulse_decoder.sv @@
// one rc channel: edge capture and pulse width to position conversion
module rcpl_pulse_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       level_i,
  input  logic [rcpl_pkg::TickW-1:0] tick_i,
  output logic [rcpl_pkg::PosW-1:0]  pos_d_o,
  output logic [rcpl_pkg::PosW-1:0]  pos_q_o
);
  import rcpl_pkg::*;

  logic             level_q;
  logic [TickW-1:0] rise_q, rise_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [TickW-1:0] width;
  logic [TickW-1:0] width_clamped;
  logic [TickW-1:0] width_offset;

  assign width = tick_i - rise_q;

  always_comb begin
    if (width < WidthMin) begin
      width_clamped = WidthMin;
    end else if (width > WidthMax) begin
      width_clamped = WidthMax;
    end else begin
      width_clamped = width;
    end
  end

  // offset is at most 4000, so the position tops out at 250
  assign width_offset = width_clamped - WidthMin;

  always_comb begin
    rise_d = rise_q;
    pos_d  = pos_q;
    if (level_i && !level_q) begin
      rise_d = tick_i;
    end else if (!level_i && level_q) begin
      pos_d = width_offset[PosW+3:4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      rise_q  <= '0;
      pos_q   <= PosNone;
    end else if (en_i) begin
      level_q <= level_i;
      rise_q  <= rise_d;
      pos_q   <= pos_d;
    end
  end

  assign pos_d_o = pos_d;
  assign pos_q_o = pos_q;

endmodule

@@ rtl/core/rc_pulse_light_controller_core.sv @@
// top level of the rc pulse light controller
//
// Each input item is one tick of the 4 MHz pulse timer carrying the switch
// channel, throttle channel and button pin levels. Every accepted item
// produces exactly one result item: front light, rear duty, both channel
// positions, the neutral position and a capture strobe.
// Both channels use valid/ready. The whole tick is evaluated combinationally
// from the state registers into the result register; the result shows in
// the next cycle, and a new item is taken every cycle while no stall holds.
// The result register is the only buffer: while the receiver stalls with a
// result pending, in_ready_o drops and the tick state holds.
// Pulse widths are measured as tick differences, clamped to 4000..8000 ticks
// and turned into positions 0..250; 255 means no pulse seen yet. Outputs
// stay dark until a first throttle pulse arrives.
// Reset loads the register defaults, clears the timers and sets neutral to
// 125; nothing sweeps after reset. The APB port is always ready and should
// only be written while no item is in flight.
module rc_pulse_light_controller_core #(
  parameter int unsigned NumChannels = rcpl_pkg::NumChannelsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       switch_level_i,
  input  logic                       throttle_level_i,
  input  logic                       button_level_i,

  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       front_light_o,
  output logic [rcpl_pkg::DutyW-1:0] rear_duty_o,
  output logic [rcpl_pkg::PosW-1:0]  switch_position_o,
  output logic [rcpl_pkg::PosW-1:0]  throttle_position_o,
  output logic [rcpl_pkg::PosW-1:0]  neutral_position_o,
  output logic                       neutral_captured_o,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcpl_pkg::AddrW-1:0] paddr,
  input  logic [rcpl_pkg::DataW-1:0] pwdata,
  output logic [rcpl_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import rcpl_pkg::*;

  // configuration registers
  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_we;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_period    <= PeriodReset;
      cfg_q.button_hold_steps <= HoldReset;
      cfg_q.light_on_below    <= OnBelowReset;
      cfg_q.light_off_above   <= OffAboveReset;
      cfg_q.brake_margin      <= BrakeReset;
      cfg_q.release_margin    <= ReleaseReset;
      cfg_q.tail_duty         <= TailReset;
    end else if (cfg_we) begin
      unique case (reg_idx)
        RegControlPeriod: cfg_q.control_period    <= pwdata[TickW-1:0];
        RegButtonHold:    cfg_q.button_hold_steps <= pwdata[HoldW-1:0];
        RegLightOnBelow:  cfg_q.light_on_below    <= pwdata[PosW-1:0];
        RegLightOffAbove: cfg_q.light_off_above   <= pwdata[PosW-1:0];
        RegBrakeMargin:   cfg_q.brake_margin      <= pwdata[PosW-1:0];
        RegReleaseMargin: cfg_q.release_margin    <= pwdata[PosW-1:0];
        RegTailDuty:      cfg_q.tail_duty         <= pwdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegControlPeriod: prdata = DataW'(cfg_q.control_period);
      RegButtonHold:    prdata = DataW'(cfg_q.button_hold_steps);
      RegLightOnBelow:  prdata = DataW'(cfg_q.light_on_below);
      RegLightOffAbove: prdata = DataW'(cfg_q.light_off_above);
      RegBrakeMargin:   prdata = DataW'(cfg_q.brake_margin);
      RegReleaseMargin: prdata = DataW'(cfg_q.release_margin);
      RegTailDuty:      prdata = DataW'(cfg_q.tail_duty);
      default:          prdata = '0;
    endcase
  end

  // handshake
  logic in_accept;
  logic out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // tick counter and channel decoders
  logic [TickW-1:0] tick_q;
  logic [PosW-1:0]  pos_d [NumChannels];
  logic [PosW-1:0]  pos_q [NumChannels];
  logic [PosW-1:0]  sw_pos;
  logic [PosW-1:0]  th_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (in_accept) begin
      tick_q <= tick_q + 16'd1;
    end
  end

  for (genvar c = 0; c < NumChannels; c++) begin : g_chan
    logic level;
    if (c == 0) begin : g_sw
      assign level = switch_level_i;
    end else if (c == 1) begin : g_th
      assign level = throttle_level_i;
    end else begin : g_idle
      assign level = 1'b0;
    end

    rcpl_pulse_decoder u_dec (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (in_accept),
      .level_i (level),
      .tick_i  (tick_q),
      .pos_d_o (pos_d[c]),
      .pos_q_o (pos_q[c])
    );
  end

  assign sw_pos = pos_d[0];
  if (NumChannels >= 2) begin : g_th_pos
    assign th_pos = pos_d[1];
  end else begin : g_th_none
    assign th_pos = PosNone;
  end

  // control state
  logic             active_q, active_d;
  logic             lights_q, lights_d;
  logic [DutyW-1:0] duty_q, duty_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic [TickW-1:0] period_q, period_d;
  logic [PosW-1:0]  neutral_q, neutral_d;
  logic             captured;

  logic             activating;
  logic [TickW-1:0] period_len;
  logic [TickW-1:0] period_inc;
  logic             step;
  logic             lights_base;
  logic signed [PosW+1:0] th_s;
  logic signed [PosW+1:0] brake_lvl;
  logic signed [PosW+1:0] release_lvl;

  assign activating = !active_q && (th_pos != PosNone);
  assign active_d   = active_q || activating;
  assign period_len = (cfg_q.control_period == '0) ? 16'd1 : cfg_q.control_period;
  assign period_inc = (activating ? '0 : period_q) + 16'd1;
  assign step       = active_d && (period_inc >= period_len);

  assign th_s        = $signed({2'b00, th_pos});
  assign brake_lvl   = $signed({2'b00, neutral_d}) - $signed({2'b00, cfg_q.brake_margin});
  assign release_lvl = $signed({2'b00, neutral_d}) - $signed({2'b00, cfg_q.release_margin});
  assign lights_base = activating ? 1'b1 : lights_q;

  always_comb begin
    hold_d    = hold_q;
    neutral_d = neutral_q;
    captured  = 1'b0;
    period_d  = period_q;
    lights_d  = lights_base;
    duty_d    = activating ? DutyInit : duty_q;

    if (active_d) begin
      period_d = step ? '0 : period_inc;
    end

    if (step) begin
      // button is active low
      if (!button_level_i) begin
        if (hold_q >= cfg_q.button_hold_steps) begin
          neutral_d = th_pos;
          captured  = 1'b1;
          hold_d    = '0;
        end else begin
          hold_d = hold_q + 11'd1;
        end
      end else begin
        hold_d = '0;
      end

      if (sw_pos < cfg_q.light_on_below) begin
        lights_d = 1'b1;
      end else if (sw_pos > cfg_q.light_off_above) begin
        lights_d = 1'b0;
      end

      // between the two levels the duty holds
      if (th_s < brake_lvl) begin
        duty_d = DutyFull;
      end else if (th_s >= release_lvl) begin
        duty_d = lights_d ? cfg_q.tail_duty : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      lights_q  <= 1'b0;
      duty_q    <= DutyInit;
      hold_q    <= '0;
      period_q  <= '0;
      neutral_q <= NeutralReset;
    end else if (in_accept) begin
      active_q  <= active_d;
      lights_q  <= lights_d;
      duty_q    <= duty_d;
      hold_q    <= hold_d;
      period_q  <= period_d;
      neutral_q <= neutral_d;
    end
  end

  // result register
  logic             front_q;
  logic [DutyW-1:0] rear_q;
  logic [PosW-1:0]  sw_out_q;
  logic [PosW-1:0]  th_out_q;
  logic [PosW-1:0]  neutral_out_q;
  logic             captured_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      front_q       <= active_d && lights_d;
      rear_q        <= active_d ? duty_d : '0;
      sw_out_q      <= sw_pos;
      th_out_q      <= th_pos;
      neutral_out_q <= neutral_d;
      captured_q    <= captured;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign front_light_o       = front_q;
  assign rear_duty_o         = rear_q;
  assign switch_position_o   = sw_out_q;
  assign throttle_position_o = th_out_q;
  assign neutral_position_o  = neutral_out_q;
  assign neutral_captured_o  = captured_q;

`ifndef SYNTHESIS
  // once a throttle pulse was seen the block stays active
  a_active_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |=> active_q)
    else $error("active dropped");

  // the period counter only runs while active
  a_period_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> period_q == '0)
    else $error("period counter moved while idle");

  // the state must not advance while a result is stuck at the output
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(tick_q) && $stable(pos_q[0]))
    else $error("state advanced under stall");
`endif

endmodule
